// ===== src/sjps_pkg.sv =====
// ----------------------------------------------------------------------------
// sjps_pkg
// shared types and constants of the servo jog/park sequencer
// ----------------------------------------------------------------------------
package sjps_pkg;

    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int NUM_JOINTS      = 4;
    localparam int JOINT_IDX_W     = 2;
    localparam int OUT_ANGLE_W     = 16;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = 1;
    localparam int QUEUE_CNT_W     = 2;

    // park pass thresholds and targets
    localparam int PARK_SKIP_J1    = 55;
    localparam int PARK_J3_TARGET  = -40;
    localparam int PARK_J1_TARGET  = 30;
    localparam int PARK_J2_OFFSET  = 30;
    localparam int PARK_J2_J1_MIN  = 20;
    localparam int PARK_J3_J1_MIN  = 50;

    localparam logic [JOINT_IDX_W-1:0] JOINT_BASE = 2'd0;
    localparam logic [JOINT_IDX_W-1:0] JOINT_ONE  = 2'd1;
    localparam logic [JOINT_IDX_W-1:0] JOINT_TWO  = 2'd2;
    localparam logic [JOINT_IDX_W-1:0] JOINT_WRST = 2'd3;

    typedef enum logic [1:0] {
        JOG_NONE,
        JOG_UP,
        JOG_DOWN
    } t_jog;

    typedef struct packed {
        logic                        park;
        t_jog [NUM_JOINTS-1:0]       jog;
        logic                        has_jog;
        logic [JOINT_IDX_W-1:0]      last_jog;
    } t_tick_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PARK,
        BK_JOG
    } t_back_state;

endpackage

// ===== src/sjps_if.sv =====
// ----------------------------------------------------------------------------
// sjps_if
// valid/ready channels for key ticks and joint commands
// ----------------------------------------------------------------------------
interface sjps_tick_if;
    logic valid;
    logic ready;
    logic park_request;
    logic base_up;
    logic base_down;
    logic joint1_up;
    logic joint1_down;
    logic joint2_up;
    logic joint2_down;
    logic joint3_up;
    logic joint3_down;

    modport source (
        output valid, park_request, base_up, base_down, joint1_up, joint1_down,
               joint2_up, joint2_down, joint3_up, joint3_down,
        input  ready
    );
    modport sink (
        input  valid, park_request, base_up, base_down, joint1_up, joint1_down,
               joint2_up, joint2_down, joint3_up, joint3_down,
        output ready
    );
endinterface

interface sjps_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic [sjps_pkg::JOINT_IDX_W-1:0]       joint_index;
    logic signed [sjps_pkg::OUT_ANGLE_W-1:0] joint_angle;
    logic                                   last;

    modport source (output valid, joint_index, joint_angle, last, input ready);
    modport sink (input valid, joint_index, joint_angle, last, output ready);
endinterface

// ===== src/sjps_front.sv =====
// ----------------------------------------------------------------------------
// sjps_front
// accepts key ticks and turns them into per-joint jog codes
// ----------------------------------------------------------------------------
module sjps_front (
    sjps_tick_if.sink               i_tick,
    output logic                    o_push_valid,
    output sjps_pkg::t_tick_cmd     o_push_data,
    input  logic                    i_push_ready
);
    import sjps_pkg::*;

    logic [NUM_JOINTS-1:0] s_up;
    logic [NUM_JOINTS-1:0] s_down;
    t_tick_cmd             s_cmd;

    assign s_up   = {i_tick.joint3_up, i_tick.joint2_up, i_tick.joint1_up, i_tick.base_up};
    assign s_down = {i_tick.joint3_down, i_tick.joint2_down, i_tick.joint1_down,
                     i_tick.base_down};

    always_comb begin
        s_cmd          = '0;
        s_cmd.park     = i_tick.park_request;
        s_cmd.has_jog  = 1'b0;
        s_cmd.last_jog = JOINT_BASE;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            if (s_up[j]) begin
                s_cmd.jog[j] = JOG_UP;
            end else if (s_down[j]) begin
                s_cmd.jog[j] = JOG_DOWN;
            end else begin
                s_cmd.jog[j] = JOG_NONE;
            end
            // highest jogging joint carries the last flag
            if (s_up[j] || s_down[j]) begin
                s_cmd.has_jog  = 1'b1;
                s_cmd.last_jog = JOINT_IDX_W'(j);
            end
        end
    end

    assign o_push_valid = i_tick.valid;
    assign o_push_data  = s_cmd;
    assign i_tick.ready = i_push_ready;

endmodule

// ===== src/sjps_queue.sv =====
// ----------------------------------------------------------------------------
// sjps_queue
// short fifo of decoded ticks between front and back
// ----------------------------------------------------------------------------
module sjps_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push_valid,
    input  sjps_pkg::t_tick_cmd     i_push_data,
    output logic                    o_push_ready,
    output logic                    o_pop_valid,
    output sjps_pkg::t_tick_cmd     o_pop_data,
    input  logic                    i_pop_ready
);
    import sjps_pkg::*;

    t_tick_cmd               r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [QUEUE_CNT_W-1:0]  r_count;
    logic                    s_push;
    logic                    s_pop;

    assign o_push_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign s_push       = i_push_valid && o_push_ready;
    assign s_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (s_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (s_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            if (s_push && !s_pop) begin
                r_count <= r_count + QUEUE_CNT_W'(1);
            end else if (s_pop && !s_push) begin
                r_count <= r_count - QUEUE_CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 && !i_push_valid) |=> (r_count == '0))
        else $error("queue filled without a push");

endmodule

// ===== src/sjps_back.sv =====
// ----------------------------------------------------------------------------
// sjps_back
// joint angle store; runs the park and jog passes, when the output is not stalled, one joint per cycle
// ----------------------------------------------------------------------------
module sjps_back #(
    parameter int ANGLE_WIDTH = sjps_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_pop_valid,
    input  sjps_pkg::t_tick_cmd     i_pop_data,
    output logic                    o_pop_ready,
    sjps_cmd_if.source              o_cmd
);
    import sjps_pkg::*;

    localparam int AW = ANGLE_WIDTH;
    localparam logic signed [AW:0] C_SKIP_J1 = (AW+1)'(PARK_SKIP_J1);
    localparam logic signed [AW:0] C_J3_TGT  = (AW+1)'(PARK_J3_TARGET);
    localparam logic signed [AW:0] C_J1_TGT  = (AW+1)'(PARK_J1_TARGET);
    localparam logic signed [AW:0] C_J2_OFS  = (AW+1)'(PARK_J2_OFFSET);
    localparam logic signed [AW:0] C_J2_MIN  = (AW+1)'(PARK_J2_J1_MIN);
    localparam logic signed [AW:0] C_J3_MIN  = (AW+1)'(PARK_J3_J1_MIN);
    localparam logic signed [AW:0] C_ONE     = (AW+1)'(1);
    localparam logic signed [AW:0] C_MONE    = -(AW+1)'(1);

    t_back_state              r_state;
    t_back_state              n_state;
    logic [JOINT_IDX_W-1:0]   r_slot;
    logic [JOINT_IDX_W-1:0]   n_slot;
    t_tick_cmd                r_cmd;
    logic [AW-1:0]            r_ang [NUM_JOINTS];

    logic                     r_out_valid;
    logic [JOINT_IDX_W-1:0]   r_out_idx;
    logic [OUT_ANGLE_W-1:0]   r_out_angle;
    logic                     r_out_last;

    logic signed [AW:0]       w_a0;
    logic signed [AW:0]       w_a1;
    logic signed [AW:0]       w_a3;
    logic signed [AW:0]       w_cur;
    logic signed [AW:0]       w_tgt;
    logic signed [AW:0]       w_step;
    logic [AW-1:0]            s_cur;
    logic [AW-1:0]            s_park_new;
    logic                     s_skip;

    logic                     s_emit;
    logic [AW-1:0]            s_new;
    logic                     s_last;
    logic                     s_out_free;
    logic                     s_advance;
    logic                     s_pop;
    logic                     s_load;
    logic [AW+OUT_ANGLE_W-1:0] s_ext;

    // park step datapath
    assign s_cur = r_ang[r_slot];
    assign w_a0  = $signed({r_ang[0][AW-1], r_ang[0]});
    assign w_a1  = $signed({r_ang[1][AW-1], r_ang[1]});
    assign w_a3  = $signed({r_ang[3][AW-1], r_ang[3]});
    assign w_cur = $signed({s_cur[AW-1], s_cur});

    always_comb begin
        w_tgt = '0;
        unique case (r_slot)
            JOINT_BASE: w_tgt = (w_a0 != '0 && w_a1 != C_J1_TGT) ? w_a0 : '0;
            JOINT_ONE:  w_tgt = (w_a0 != '0) ? C_J1_TGT : '0;
            JOINT_TWO:  w_tgt = (w_a0 != '0 || w_a1 > C_J2_MIN) ? (w_a1 + C_J2_OFS) : '0;
            JOINT_WRST: w_tgt = (w_a1 > C_J3_MIN) ? C_J3_TGT : '0;
            default:    w_tgt = '0;
        endcase
    end

    always_comb begin
        if (w_cur < w_tgt) begin
            w_step = C_ONE;
        end else if (w_cur > w_tgt) begin
            w_step = C_MONE;
        end else begin
            w_step = '0;
        end
        // base and wrist move two at a time away from plus or minus one
        if ((r_slot == JOINT_BASE || r_slot == JOINT_WRST) &&
            w_cur != C_ONE && w_cur != C_MONE) begin
            w_step = w_step <<< 1;
        end
    end

    assign s_park_new = s_cur + w_step[AW-1:0];
    assign s_skip     = (w_a1 > C_SKIP_J1) && (w_a3 != C_J3_TGT) && (r_slot != JOINT_WRST);
    assign s_out_free = !r_out_valid || o_cmd.ready;

    // step outputs
    always_comb begin
        s_emit    = 1'b0;
        s_new     = s_cur;
        s_last    = 1'b0;
        s_advance = 1'b0;
        s_pop     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                s_pop = 1'b1;
            end
            BK_PARK: begin
                s_emit    = !s_skip;
                s_new     = s_park_new;
                s_last    = (r_slot == JOINT_WRST) && !r_cmd.has_jog;
                s_advance = s_skip || s_out_free;
            end
            BK_JOG: begin
                case (r_cmd.jog[r_slot])
                    JOG_UP: begin
                        s_emit = 1'b1;
                        s_new  = s_cur + AW'(1);
                    end
                    JOG_DOWN: begin
                        s_emit = 1'b1;
                        s_new  = s_cur - AW'(1);
                    end
                    default: begin
                        s_emit = 1'b0;
                    end
                endcase
                s_last    = (r_slot == r_cmd.last_jog);
                s_advance = !s_emit || s_out_free;
                s_pop     = s_advance && (r_slot == JOINT_WRST);
            end
            default: begin
                s_pop = 1'b0;
            end
        endcase
    end

    assign o_pop_ready = s_pop;
    assign s_load      = s_emit && s_out_free;
    assign s_ext       = {{OUT_ANGLE_W{1'b0}}, s_new};

    // next state
    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        unique case (r_state)
            BK_IDLE: begin
                if (i_pop_valid) begin
                    n_state = i_pop_data.park ? BK_PARK : BK_JOG;
                    n_slot  = JOINT_BASE;
                end
            end
            BK_PARK: begin
                if (s_advance) begin
                    n_slot = r_slot + JOINT_IDX_W'(1);
                    if (r_slot == JOINT_WRST) begin
                        n_state = BK_JOG;
                    end
                end
            end
            BK_JOG: begin
                if (s_advance) begin
                    n_slot = r_slot + JOINT_IDX_W'(1);
                    if (r_slot == JOINT_WRST) begin
                        if (i_pop_valid) begin
                            n_state = i_pop_data.park ? BK_PARK : BK_JOG;
                        end else begin
                            n_state = BK_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
                n_slot  = JOINT_BASE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_slot      <= JOINT_BASE;
            r_out_valid <= 1'b0;
            for (int j = 0; j < NUM_JOINTS; j++) begin
                r_ang[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            if (s_out_free) begin
                r_out_valid <= s_emit;
            end
            if (s_load) begin
                r_ang[r_slot] <= s_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_pop && i_pop_valid) begin
            r_cmd <= i_pop_data;
        end
        if (s_load) begin
            r_out_idx   <= r_slot;
            r_out_angle <= s_ext[OUT_ANGLE_W-1:0];
            r_out_last  <= s_last;
        end
    end

    assign o_cmd.valid       = r_out_valid;
    assign o_cmd.joint_index = r_out_idx;
    assign o_cmd.joint_angle = r_out_angle;
    assign o_cmd.last        = r_out_last;

    a_park_needs_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_PARK) |-> r_cmd.park)
        else $error("park pass without park request");

    a_idle_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_IDLE && !i_pop_valid) |=> (r_state == BK_IDLE))
        else $error("back left idle without an item");

    a_reset_clean: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_state == BK_IDLE && !r_out_valid))
        else $error("back not clean after reset");

    a_park_last_wrist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_PARK && s_load && s_last) |-> (r_slot == JOINT_WRST))
        else $error("last flag before the wrist in park pass");

endmodule

// ===== src/servo_jog_park_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// servo_jog_park_sequencer_core
// four-joint jog and park sequencer: key ticks in, joint commands out
// ----------------------------------------------------------------------------
// an idle block shows the first command of a tick once it has passed the queue, the back
// state register and the output register; joints ahead of it that emit nothing take a turn
// the back sequencer walks all four joints, first in a park pass when park is held,
// then in a jog pass, one joint per cycle unless the output stalls an emitting joint
// a two-tick queue lets new ticks in while the back is busy
// reset: synchronous active low; all joint angles zero, queue and output empty
module servo_jog_park_sequencer_core #(
    parameter int ANGLE_WIDTH = sjps_pkg::ANGLE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sjps_tick_if.sink   i_tick,
    sjps_cmd_if.source  o_cmd
);
    import sjps_pkg::*;

    logic       s_push_valid;
    logic       s_push_ready;
    t_tick_cmd  s_push_data;
    logic       s_pop_valid;
    logic       s_pop_ready;
    t_tick_cmd  s_pop_data;

    sjps_front u_front (
        .i_tick       (i_tick),
        .o_push_valid (s_push_valid),
        .o_push_data  (s_push_data),
        .i_push_ready (s_push_ready)
    );

    sjps_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (s_push_valid),
        .i_push_data  (s_push_data),
        .o_push_ready (s_push_ready),
        .o_pop_valid  (s_pop_valid),
        .o_pop_data   (s_pop_data),
        .i_pop_ready  (s_pop_ready)
    );

    sjps_back #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (s_pop_valid),
        .i_pop_data  (s_pop_data),
        .o_pop_ready (s_pop_ready),
        .o_cmd       (o_cmd)
    );

endmodule

// ===== tb/sjps_cmd_checker.sv =====
// ----------------------------------------------------------------------------
// sjps_cmd_checker
// watches the tick and command channels of the jog/park sequencer, keeps its
// own copy of the four joint angles, works out the commands of every accepted
// tick and compares each accepted command with the oldest one still due
// ----------------------------------------------------------------------------
module sjps_cmd_checker #(
    parameter int ANGLE_WIDTH = sjps_pkg::ANGLE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sjps_tick_if i_tick,
    sjps_cmd_if  i_cmd,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_ticks,
    output int   o_cmds,
    output int   o_park_ticks,
    output int   o_skipped,
    output int   o_wraps,
    output int   o_full_ticks
);
    import sjps_pkg::*;

    typedef logic signed [ANGLE_WIDTH-1:0] t_angle;

    typedef struct {
        logic [JOINT_IDX_W-1:0] joint;
        logic [OUT_ANGLE_W-1:0] angle;
        logic                   last;
    } t_joint_cmd;

    t_angle     joint_pos [NUM_JOINTS];
    t_joint_cmd due_cmds [$];

    function automatic void log_failure(input string what);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t checker: %s", $time, what);
        end
    endfunction

    function automatic void move_joint(input int j, input longint step);
        longint     moved;
        t_joint_cmd c;
        moved = longint'(joint_pos[j]) + step;
        joint_pos[j] = t_angle'(moved);
        if (longint'(joint_pos[j]) != moved) begin
            o_wraps++;
        end
        c.joint = j[JOINT_IDX_W-1:0];
        c.angle = OUT_ANGLE_W'(unsigned'(joint_pos[j]));
        c.last  = 1'b0;
        due_cmds.insert(due_cmds.size(), c);
    endfunction

    // keys: bit 0 park, then up/down pairs for joints 0 to 3
    function automatic void advance_joints(input logic [8:0] keys);
        int     j;
        int     first;
        longint a0;
        longint a1;
        longint a3;
        longint here;
        longint goal;
        longint step;
        first = due_cmds.size();
        o_ticks++;
        if (keys[0]) begin
            o_park_ticks++;
            for (j = 0; j < NUM_JOINTS; j++) begin
                a0   = joint_pos[JOINT_BASE];
                a1   = joint_pos[JOINT_ONE];
                a3   = joint_pos[JOINT_WRST];
                here = joint_pos[j];
                if (a1 > PARK_SKIP_J1 && a3 != PARK_J3_TARGET && j != JOINT_WRST) begin
                    o_skipped++;
                    continue;
                end
                if (j == JOINT_BASE && a0 != 0 && a1 != PARK_J1_TARGET) begin
                    goal = a0;
                end else if (j == JOINT_ONE && a0 != 0) begin
                    goal = PARK_J1_TARGET;
                end else if (j == JOINT_TWO && (a0 != 0 || a1 > PARK_J2_J1_MIN)) begin
                    goal = a1 + PARK_J2_OFFSET;
                end else if (j == JOINT_WRST && a1 > PARK_J3_J1_MIN) begin
                    goal = PARK_J3_TARGET;
                end else begin
                    goal = 0;
                end
                step = (here < goal) ? 1 : (here > goal) ? -1 : 0;
                if ((j == JOINT_BASE || j == JOINT_WRST) && here != 1 && here != -1) begin
                    step = step * 2;
                end
                move_joint(j, step);
            end
        end
        for (j = 0; j < NUM_JOINTS; j++) begin
            if (keys[1 + 2 * j]) begin
                move_joint(j, 1);
            end else if (keys[2 + 2 * j]) begin
                move_joint(j, -1);
            end
        end
        if (due_cmds.size() > first) begin
            due_cmds[due_cmds.size() - 1].last = 1'b1;
        end
        if (due_cmds.size() - first == 8) begin
            o_full_ticks++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_joint_cmd want;
        if (!i_rst_n) begin
            foreach (joint_pos[j]) begin
                joint_pos[j] = '0;
            end
            due_cmds.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                o_cmds++;
                if (due_cmds.size() == 0) begin
                    log_failure($sformatf("unexpected command: joint %0d angle %0d last %0b",
                        i_cmd.joint_index, $signed(i_cmd.joint_angle), i_cmd.last));
                end else begin
                    want = due_cmds.pop_front();
                    if (want.joint !== i_cmd.joint_index || want.angle !== i_cmd.joint_angle
                            || want.last !== i_cmd.last) begin
                        log_failure($sformatf({"command mismatch: expected joint %0d angle %0d",
                            " last %0b, got joint %0d angle %0d last %0b"},
                            want.joint, $signed(want.angle), want.last,
                            i_cmd.joint_index, $signed(i_cmd.joint_angle), i_cmd.last));
                    end
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                advance_joints({i_tick.joint3_down, i_tick.joint3_up,
                                i_tick.joint2_down, i_tick.joint2_up,
                                i_tick.joint1_down, i_tick.joint1_up,
                                i_tick.base_down, i_tick.base_up, i_tick.park_request});
            end
        end
        o_pending = due_cmds.size();
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives key ticks into the jog/park sequencer with random gaps and output
// stalls: a directed opening, then random segments that climb joint1 past
// the park thresholds and mix park and jog keys, and a long output hold-off;
// a separate checker does the compare
// ----------------------------------------------------------------------------
module testbench;
    import sjps_pkg::*;

    typedef enum int {
        KEYS_RANDOM,
        KEYS_RAISE,
        KEYS_LOWER,
        KEYS_QUIET
    } t_jog_mode;

    logic i_clk;
    logic i_rst_n;

    sjps_tick_if tick_ch();
    sjps_cmd_if  cmd_ch();

    int fail_count;
    int pending;
    int ticks;
    int cmds;
    int park_ticks;
    int skipped;
    int wraps;
    int full_ticks;

    bit tx_calm;
    bit rx_calm;
    bit hold_req;

    servo_jog_park_sequencer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_ch),
        .o_cmd   (cmd_ch)
    );

    sjps_cmd_checker watcher (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_ch),
        .i_cmd        (cmd_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_ticks      (ticks),
        .o_cmds       (cmds),
        .o_park_ticks (park_ticks),
        .o_skipped    (skipped),
        .o_wraps      (wraps),
        .o_full_ticks (full_ticks)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    initial begin : cmd_sink
        int hold_left;
        hold_left = 0;
        cmd_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = 250;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                cmd_ch.ready <= 1'b0;
            end else begin
                cmd_ch.ready <= rx_calm || $urandom_range(99) >= 35;
            end
        end
    end

    // keys: bit 0 park, then up/down pairs for joints 0 to 3
    task automatic send_tick(input logic [8:0] keys);
        @(negedge i_clk);
        while (!tx_calm && $urandom_range(99) < 35) begin
            tick_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        tick_ch.park_request <= keys[0];
        tick_ch.base_up      <= keys[1];
        tick_ch.base_down    <= keys[2];
        tick_ch.joint1_up    <= keys[3];
        tick_ch.joint1_down  <= keys[4];
        tick_ch.joint2_up    <= keys[5];
        tick_ch.joint2_down  <= keys[6];
        tick_ch.joint3_up    <= keys[7];
        tick_ch.joint3_down  <= keys[8];
        tick_ch.valid        <= 1'b1;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [8:0] opening [$];
        logic [8:0] keys;
        t_jog_mode  mode [NUM_JOINTS];
        int         park_pcts [4];
        int         park_pct;
        int         seg_len;
        int         seg;
        int         sent;
        int         k;
        int         j;
        bit         up;
        bit         down;

        park_pcts = '{0, 30, 70, 100};
        i_rst_n = 1'b0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        hold_req = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.park_request = 1'b0;
        tick_ch.base_up = 1'b0;
        tick_ch.base_down = 1'b0;
        tick_ch.joint1_up = 1'b0;
        tick_ch.joint1_down = 1'b0;
        tick_ch.joint2_up = 1'b0;
        tick_ch.joint2_down = 1'b0;
        tick_ch.joint3_up = 1'b0;
        tick_ch.joint3_down = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        opening.insert(opening.size(), 9'h000);
        opening.insert(opening.size(), 9'h001);
        for (k = 1; k < 9; k++) begin
            opening.insert(opening.size(), 9'h001 << k);
        end
        opening.insert(opening.size(), 9'h0AA);
        opening.insert(opening.size(), 9'h154);
        opening.insert(opening.size(), 9'h1FE);
        opening.insert(opening.size(), 9'h1FF);
        opening.insert(opening.size(), 9'h002);
        opening.insert(opening.size(), 9'h002);
        opening.insert(opening.size(), 9'h001);
        opening.insert(opening.size(), 9'h009);
        opening.insert(opening.size(), 9'h001);
        opening.insert(opening.size(), 9'h001);
        opening.insert(opening.size(), 9'h001);
        opening.insert(opening.size(), 9'h155);
        opening.insert(opening.size(), 9'h000);
        foreach (opening[i]) begin
            send_tick(opening[i]);
        end

        // random segments; the first two drive joint1 past the skip threshold
        // and then hold park so joint3 settles at its park angle
        sent = 0;
        seg = 0;
        while (sent < 150 || seg < 5) begin
            if (seg == 0) begin
                seg_len = 75;
                park_pct = 0;
                foreach (mode[i]) mode[i] = KEYS_QUIET;
                mode[JOINT_ONE] = KEYS_RAISE;
            end else if (seg == 1) begin
                seg_len = 30;
                park_pct = 100;
                foreach (mode[i]) mode[i] = KEYS_QUIET;
            end else begin
                seg_len = $urandom_range(8, 30);
                park_pct = park_pcts[$urandom_range(3)];
                foreach (mode[i]) mode[i] = t_jog_mode'($urandom_range(3));
            end
            tx_calm = (seg == 3 || seg == 4);
            rx_calm = (seg == 3);
            if (seg == 4) begin
                hold_req = 1'b1;
                park_pct = 100;
            end
            repeat (seg_len) begin
                keys = '0;
                keys[0] = $urandom_range(99) < park_pct;
                for (j = 0; j < NUM_JOINTS; j++) begin
                    case (mode[j])
                        KEYS_RAISE: begin
                            up = $urandom_range(99) < 90;
                            down = $urandom_range(99) < 20;
                        end
                        KEYS_LOWER: begin
                            up = $urandom_range(99) < 5;
                            down = $urandom_range(99) < 85;
                        end
                        KEYS_QUIET: begin
                            up = $urandom_range(99) < 3;
                            down = $urandom_range(99) < 3;
                        end
                        default: begin
                            up = $urandom_range(99) < 30;
                            down = $urandom_range(99) < 30;
                        end
                    endcase
                    keys[1 + 2 * j] = up;
                    keys[2 + 2 * j] = down;
                end
                send_tick(keys);
                sent++;
            end
            seg++;
        end

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        repeat (6) send_tick(9'h001);
        send_tick(9'h1FF);

        @(negedge i_clk);
        tick_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge i_clk);

        $display("run: %0d ticks, %0d commands checked, %0d with park held",
                 ticks, cmds, park_ticks);
        $display("run: %0d park visits skipped, %0d ticks gave eight commands, %0d wraps",
                 skipped, full_ticks, wraps);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
